// ===== src/ywb_pkg.sv =====
// Shared types and constants for the YCbCr 4:2:0 white balance block.
// No dependencies; used by the channel interfaces and the top level.
package ywb_pkg;

  localparam int unsigned Lanes = 4;
  localparam int unsigned GainW = 16;

  // register indexes
  typedef enum logic {
    RegRedGain  = 1'b0,
    RegBlueGain = 1'b1
  } ywb_reg_t;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue_in;
    logic [7:0] chroma_red_in;
  } ywb_in_t;

  typedef struct packed {
    logic [7:0] new_luma_top_left;
    logic [7:0] new_luma_top_right;
    logic [7:0] new_luma_bottom_left;
    logic [7:0] new_luma_bottom_right;
    logic [7:0] chroma_blue_out;
    logic [7:0] chroma_red_out;
  } ywb_out_t;

  localparam logic [GainW-1:0] GainReset = 16'd256;

  // YCbCr -> RGB, scaled by 256
  localparam logic signed [17:0] RFromCr = 18'sd359;
  localparam logic signed [17:0] GFromCb = 18'sd88;
  localparam logic signed [17:0] GFromCr = 18'sd183;
  localparam logic signed [17:0] BFromCb = 18'sd454;
  localparam logic signed [8:0]  ChromaOfs = 9'sd128;

  // RGB -> Y
  localparam logic [15:0] YFromR = 16'd77;
  localparam logic [15:0] YFromG = 16'd150;
  localparam logic [15:0] YFromB = 16'd29;

  // RGB -> Cb, Cr
  localparam logic signed [16:0] CbFromR = -17'sd43;
  localparam logic signed [16:0] CbFromG = -17'sd85;
  localparam logic signed [16:0] CbFromB = 17'sd128;
  localparam logic signed [16:0] CrFromR = 17'sd128;
  localparam logic signed [16:0] CrFromG = -17'sd107;
  localparam logic signed [16:0] CrFromB = -17'sd21;

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 11'sd0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

// ===== src/ywb_in_if.sv =====
// Valid/ready channel carrying one 2x2 block with its shared Cb and Cr.
// Depends on ywb_pkg for the word type.
interface ywb_in_if
  import ywb_pkg::*;
;
  logic    valid;
  logic    ready;
  ywb_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/ywb_out_if.sv =====
// Valid/ready channel carrying one corrected 2x2 block.
// Depends on ywb_pkg for the word type.
interface ywb_out_if
  import ywb_pkg::*;
;
  logic     valid;
  logic     ready;
  ywb_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/yuv420_white_balance_unit.sv =====
// White balance of 2x2 YCbCr 4:2:0 blocks: YCbCr->RGB, R/B gain, RGB->YCbCr; a zero gain bypasses.
// Depends on ywb_pkg, ywb_in_if and ywb_out_if.
//
//  channel   dir  handshake     word
//  pix_in    in   valid/ready   four luma, Cb, Cr
//  pix_out   out  valid/ready   four new luma, new Cb, new Cr
//  cfg       in   cfg_we        cfg_index selects red or blue gain, cfg_data
//
// One word per cycle sustained while pix_out is not stalled.
// Five register stages: chroma offsets, RGB clamp, gain multiply, back conversion,
// and chroma average feeding the output register.
// rst (synchronous) clears all valid bits and sets both gains to 256.
// A stall on pix_out freezes every stage together; pix_in.ready drops with it.
module yuv420_white_balance_unit
  import ywb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  ywb_in_if.sink           pix_in,
  ywb_out_if.source        pix_out,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [GainW-1:0] cfg_data
);

  logic [GainW-1:0] red_gain;
  logic [GainW-1:0] blue_gain;
  logic             bypass;
  logic             advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_gain  <= GainReset;
      blue_gain <= GainReset;
    end else if (cfg_we) begin
      unique case (ywb_reg_t'(cfg_index))
        RegRedGain:  red_gain  <= cfg_data;
        RegBlueGain: blue_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // user must change gains only while idle (not enforced); then the flag holds for words in flight
  assign bypass = (red_gain == '0) || (blue_gain == '0);

  // ---------------- stage valids and payload ----------------
  logic v1, v2, v3, v4, v5;
  ywb_in_t raw1, raw2, raw3, raw4;

  logic signed [9:0] rofs1, gofs1, bofs1;
  logic [7:0] r2 [Lanes];
  logic [7:0] g2 [Lanes];
  logic [7:0] b2 [Lanes];
  logic [23:0] rp3 [Lanes];
  logic [23:0] bp3 [Lanes];
  logic [7:0]  g3  [Lanes];
  logic [7:0]        ny4  [Lanes];
  logic signed [8:0] cbp4 [Lanes];
  logic signed [8:0] crp4 [Lanes];
  ywb_out_t out5;

  assign advance      = !v5 || pix_out.ready;
  assign pix_in.ready = advance;
  assign pix_out.valid = v5;
  assign pix_out.data  = out5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (advance) begin
      v1 <= pix_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // ---------------- stage 1: chroma offsets ----------------
  logic signed [8:0]  cb_c, cr_c;
  logic signed [17:0] rm, gm, bm;
  logic signed [9:0]  rofs_next, gofs_next, bofs_next;

  always_comb begin
    cb_c = $signed({1'b0, pix_in.data.chroma_blue_in}) - ChromaOfs;
    cr_c = $signed({1'b0, pix_in.data.chroma_red_in}) - ChromaOfs;
    rm = RFromCr * 18'(cr_c);
    gm = GFromCb * 18'(cb_c) + GFromCr * 18'(cr_c);
    bm = BFromCb * 18'(cb_c);
    rofs_next = 10'(rm >>> 8);
    gofs_next = 10'(gm >>> 8);
    bofs_next = 10'(bm >>> 8);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw1  <= pix_in.data;
      rofs1 <= rofs_next;
      gofs1 <= gofs_next;
      bofs1 <= bofs_next;
    end
  end

  // ---------------- stage 2: RGB per pixel, clamped ----------------
  logic [7:0] y1 [Lanes];
  logic [7:0] r_next [Lanes];
  logic [7:0] g_next [Lanes];
  logic [7:0] b_next [Lanes];

  always_comb begin
    y1[0] = raw1.luma_top_left;
    y1[1] = raw1.luma_top_right;
    y1[2] = raw1.luma_bottom_left;
    y1[3] = raw1.luma_bottom_right;
    for (int i = 0; i < Lanes; i++) begin
      r_next[i] = clamp_byte($signed({3'b000, y1[i]}) + 11'(rofs1));
      g_next[i] = clamp_byte($signed({3'b000, y1[i]}) - 11'(gofs1));
      b_next[i] = clamp_byte($signed({3'b000, y1[i]}) + 11'(bofs1));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw2 <= raw1;
      r2   <= r_next;
      g2   <= g_next;
      b2   <= b_next;
    end
  end

  // ---------------- stage 3: gain multiply ----------------
  logic [23:0] rp_next [Lanes];
  logic [23:0] bp_next [Lanes];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      rp_next[i] = 24'(r2[i]) * 24'(red_gain);
      bp_next[i] = 24'(b2[i]) * 24'(blue_gain);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw3 <= raw2;
      rp3  <= rp_next;
      bp3  <= bp_next;
      g3   <= g2;
    end
  end

  // ---------------- stage 4: back to Y and chroma terms ----------------
  logic [7:0]         rc [Lanes];
  logic [7:0]         bc [Lanes];
  logic [15:0]        ys [Lanes];
  logic signed [16:0] cbs [Lanes];
  logic signed [16:0] crs [Lanes];
  logic [7:0]         ny_next  [Lanes];
  logic signed [8:0]  cbp_next [Lanes];
  logic signed [8:0]  crp_next [Lanes];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      rc[i] = (|rp3[i][23:16]) ? 8'd255 : rp3[i][15:8];
      bc[i] = (|bp3[i][23:16]) ? 8'd255 : bp3[i][15:8];
      // max sum is 255*256, so the top byte never exceeds 255
      ys[i] = YFromR * 16'(rc[i]) + YFromG * 16'(g3[i]) + YFromB * 16'(bc[i]);
      cbs[i] = CbFromR * $signed({9'd0, rc[i]}) + CbFromG * $signed({9'd0, g3[i]})
             + CbFromB * $signed({9'd0, bc[i]});
      crs[i] = CrFromR * $signed({9'd0, rc[i]}) + CrFromG * $signed({9'd0, g3[i]})
             + CrFromB * $signed({9'd0, bc[i]});
      ny_next[i]  = ys[i][15:8];
      cbp_next[i] = 9'(cbs[i] >>> 8);
      crp_next[i] = 9'(crs[i] >>> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw4 <= raw3;
      ny4  <= ny_next;
      cbp4 <= cbp_next;
      crp4 <= crp_next;
    end
  end

  // ---------------- stage 5: chroma average, bypass select ----------------
  logic signed [10:0] sum_cb, sum_cr;
  ywb_out_t           out_next;

  always_comb begin
    sum_cb = 11'(cbp4[0]) + 11'(cbp4[1]) + 11'(cbp4[2]) + 11'(cbp4[3]);
    sum_cr = 11'(crp4[0]) + 11'(crp4[1]) + 11'(crp4[2]) + 11'(crp4[3]);
    if (bypass) begin
      out_next.new_luma_top_left     = raw4.luma_top_left;
      out_next.new_luma_top_right    = raw4.luma_top_right;
      out_next.new_luma_bottom_left  = raw4.luma_bottom_left;
      out_next.new_luma_bottom_right = raw4.luma_bottom_right;
      out_next.chroma_blue_out       = raw4.chroma_blue_in;
      out_next.chroma_red_out        = raw4.chroma_red_in;
    end else begin
      out_next.new_luma_top_left     = ny4[0];
      out_next.new_luma_top_right    = ny4[1];
      out_next.new_luma_bottom_left  = ny4[2];
      out_next.new_luma_bottom_right = ny4[3];
      out_next.chroma_blue_out = clamp_byte((sum_cb >>> 2) + 11'sd128);
      out_next.chroma_red_out  = clamp_byte((sum_cr >>> 2) + 11'sd128);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out5 <= out_next;
    end
  end

  // ---------------- assertions ----------------
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (v5 && !pix_out.ready))
    else $error("input stalled without an output stall");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    (v5 && !pix_out.ready) |=> ($stable(v4) && $stable(v1) && v5))
    else $error("pipeline moved during an output stall");

  a_accept_reaches_s1: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> v1)
    else $error("accepted word lost at stage 1");

  a_s4_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (v4 && advance) |=> v5)
    else $error("stage 4 word lost before the output register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3 && !v4 && !v5))
    else $error("valid bits not cleared by reset");

endmodule
